/* sv/lmph_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lmph_pkg
// Shared widths, register indexes and reset values for the level meter.
// ----------------------------------------------------------------------------
package lmph_pkg;

    // Field widths
    localparam int CH_W     = 3;
    localparam int LEVEL_W  = 16;
    localparam int TIME_W   = 32;
    localparam int ELAPSE_W = 16;
    localparam int CFG_W    = 16;
    localparam int CFG_IDX_W = 2;

    // Packed stream widths, padded to whole bytes
    localparam int IN_BITS   = CH_W + LEVEL_W + TIME_W + ELAPSE_W;
    localparam int IN_DATA_W = ((IN_BITS + 7) / 8) * 8;
    localparam int OUT_BITS   = CH_W + 2 * LEVEL_W;
    localparam int OUT_DATA_W = ((OUT_BITS + 7) / 8) * 8;

    // Default channel count
    localparam int CHANNELS_DEFAULT = 8;

    // Register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_SMOOTHING_WEIGHT = 2'd0,
        REG_HOLD_TIME_MS     = 2'd1,
        REG_DECAY_PER_MS     = 2'd2
    } cfg_reg_t;

    // Register reset values
    localparam logic [CFG_W-1:0] SMOOTHING_WEIGHT_RST = 16'd39322;
    localparam logic [CFG_W-1:0] HOLD_TIME_MS_RST     = 16'd1500;
    localparam logic [CFG_W-1:0] DECAY_PER_MS_RST     = 16'd33;

    // Full scale of a Q0.16 level
    localparam logic [LEVEL_W-1:0] LEVEL_MAX = {LEVEL_W{1'b1}};

endpackage

/* sv/level_meter_peak_hold.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// level_meter_peak_hold
// Multi-channel level meter: exponential moving-average smoothing and peak hold/decay.
// ----------------------------------------------------------------------------
// Usage:
//   Items arrive on the s_ stream: channel, raw level, current time and time
//   since the last frame. Each item yields one result item on the m_ stream
//   with the channel's smoothed level and its peak after hold and decay.
//   Settings are written through cfg_we / cfg_index / cfg_data while idle;
//   an index beyond the last register is ignored.
// Throughput:
//   One item per clock cycle sustained while m_tready is high. m_tvalid rises
//   when its item reaches the result register: the item first sits in the input
//   register (the level and decay products are formed on the way in) while the
//   per-channel read-modify-write feeds the result register.
// Reset:
//   Clears all per-channel smoothed levels, peaks and peak times, empties
//   both stages and loads the registers with their default values.
// Stalls:
//   When m_tready is low the result register holds its item; the input
//   register still fills, and s_tready drops only once both are full.
//   A channel not below CHANNELS leaves the stores alone and reports zeros.
// ----------------------------------------------------------------------------
module level_meter_peak_hold #(
    parameter int CHANNELS = lmph_pkg::CHANNELS_DEFAULT
) (
    input  logic                              clk,
    input  logic                              rst_n,
    // configuration write port
    input  logic                              cfg_we,
    input  logic [lmph_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [lmph_pkg::CFG_W-1:0]        cfg_data,
    // input stream
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // s_tdata, from bit 0: channel[3], raw_level[16], now_ms[32],
    // elapsed_ms[16], zero padding
    input  logic [lmph_pkg::IN_DATA_W-1:0]    s_tdata,
    // result stream
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // m_tdata, from bit 0: out_channel[3], smoothed_level[16],
    // peak_level[16], zero padding
    output logic [lmph_pkg::OUT_DATA_W-1:0]   m_tdata
);

    import lmph_pkg::*;

    // Only channels reachable through the 3-bit field need storage
    localparam int CH_SPAN = 2 ** CH_W;
    localparam int DEPTH   = (CHANNELS < CH_SPAN) ? CHANNELS : CH_SPAN;
    localparam int IDX_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    // Configuration registers
    logic [CFG_W-1:0] smoothing_weight_reg;
    logic [CFG_W-1:0] hold_time_ms_reg;
    logic [CFG_W-1:0] decay_per_ms_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            smoothing_weight_reg <= SMOOTHING_WEIGHT_RST;
            hold_time_ms_reg     <= HOLD_TIME_MS_RST;
            decay_per_ms_reg     <= DECAY_PER_MS_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_SMOOTHING_WEIGHT: smoothing_weight_reg <= cfg_data;
                REG_HOLD_TIME_MS:     hold_time_ms_reg     <= cfg_data;
                REG_DECAY_PER_MS:     decay_per_ms_reg     <= cfg_data;
                default: ;
            endcase
        end
    end

    // Unpack input item
    logic [CH_W-1:0]     s_channel;
    logic [LEVEL_W-1:0]  s_raw;
    logic [TIME_W-1:0]   s_now;
    logic [ELAPSE_W-1:0] s_elapsed;

    assign s_channel = s_tdata[CH_W-1:0];
    assign s_raw     = s_tdata[CH_W +: LEVEL_W];
    assign s_now     = s_tdata[CH_W+LEVEL_W +: TIME_W];
    assign s_elapsed = s_tdata[CH_W+LEVEL_W+TIME_W +: ELAPSE_W];

    // Products that depend only on the item and settings, formed on entry
    logic [LEVEL_W:0]     w_comp;
    logic [31:0]          raw_prod;
    logic [31:0]          decay_prod;
    logic [LEVEL_W-1:0]   decay_sat;

    assign w_comp     = 17'h10000 - {1'b0, smoothing_weight_reg};
    assign raw_prod   = 32'(s_raw) * 32'(w_comp);
    assign decay_prod = 32'(s_elapsed) * 32'(decay_per_ms_reg);
    assign decay_sat  = (|decay_prod[31:16]) ? LEVEL_MAX : decay_prod[15:0];

    // Pipeline control
    logic in_valid_reg;
    logic out_valid_reg;
    logic advance;
    logic s_take;

    assign advance  = !out_valid_reg || m_tready;
    assign s_tready = !in_valid_reg || advance;
    assign s_take   = s_tvalid && s_tready;
    assign m_tvalid = out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s_tready)
            begin
                in_valid_reg <= s_tvalid;
            end
            if (advance)
            begin
                out_valid_reg <= in_valid_reg;
            end
        end
    end

    // Input register
    logic [CH_W-1:0]    ch_reg;
    logic [31:0]        raw_term_reg;
    logic [TIME_W-1:0]  now_reg;
    logic [LEVEL_W-1:0] decay_reg;

    always_ff @(posedge clk)
    begin
        if (s_take)
        begin
            ch_reg       <= s_channel;
            raw_term_reg <= raw_prod;
            now_reg      <= s_now;
            decay_reg    <= decay_sat;
        end
    end

    // Per-channel stores
    logic [LEVEL_W-1:0] sm_store_reg   [DEPTH];
    logic [LEVEL_W-1:0] pk_store_reg   [DEPTH];
    logic [TIME_W-1:0]  pt_store_reg   [DEPTH];

    logic               in_range;
    logic [IDX_W-1:0]   idx;
    logic               commit;

    assign in_range = 32'(ch_reg) < 32'(CHANNELS);
    assign idx      = IDX_W'(ch_reg);
    assign commit   = advance && in_valid_reg && in_range;

    // Smoothing and peak update
    logic [LEVEL_W-1:0]   sm_old;
    logic [LEVEL_W-1:0]   pk_old;
    logic [TIME_W-1:0]    pt_old;
    logic [31:0]          old_term;
    logic [32:0]          acc;
    logic [LEVEL_W-1:0]   sm_new;
    logic                 new_peak;
    logic [LEVEL_W-1:0]   pk_mid;
    logic [TIME_W-1:0]    pt_new;
    logic [TIME_W-1:0]    age;
    logic                 decay_on;
    logic [LEVEL_W-1:0]   pk_new;

    always_comb
    begin
        sm_old   = sm_store_reg[idx];
        pk_old   = pk_store_reg[idx];
        pt_old   = pt_store_reg[idx];
        old_term = 32'(sm_old) * 32'(smoothing_weight_reg);
        acc      = {1'b0, raw_term_reg} + {1'b0, old_term} + 33'd32768;
        sm_new   = acc[32] ? LEVEL_MAX : acc[31:16];
        new_peak = sm_new > pk_old;
        pk_mid   = new_peak ? sm_new : pk_old;
        pt_new   = new_peak ? now_reg : pt_old;
        age      = now_reg - pt_new;
        decay_on = age > {16'd0, hold_time_ms_reg};
        if (!decay_on)
        begin
            pk_new = pk_mid;
        end
        else if (pk_mid > decay_reg)
        begin
            pk_new = pk_mid - decay_reg;
        end
        else
        begin
            pk_new = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < DEPTH; i++)
            begin
                sm_store_reg[i] <= '0;
                pk_store_reg[i] <= '0;
                pt_store_reg[i] <= '0;
            end
        end
        else if (commit)
        begin
            sm_store_reg[idx] <= sm_new;
            pk_store_reg[idx] <= pk_new;
            pt_store_reg[idx] <= pt_new;
        end
    end

    // Result register
    logic [CH_W-1:0]    out_ch_reg;
    logic [LEVEL_W-1:0] out_sm_reg;
    logic [LEVEL_W-1:0] out_pk_reg;

    always_ff @(posedge clk)
    begin
        if (advance && in_valid_reg)
        begin
            out_ch_reg <= ch_reg;
            out_sm_reg <= in_range ? sm_new : '0;
            out_pk_reg <= in_range ? pk_new : '0;
        end
    end

    assign m_tdata = {{(OUT_DATA_W - OUT_BITS){1'b0}}, out_pk_reg, out_sm_reg, out_ch_reg};

    // Assertions
    a_out_of_range_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && (32'(out_ch_reg) >= 32'(CHANNELS)))
            |-> (out_sm_reg == '0 && out_pk_reg == '0))
        else $error("out-of-range channel reported non-zero levels");

    a_stage_moves: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && in_valid_reg) |=> out_valid_reg)
        else $error("item lost between input and result register");

    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid_reg |-> s_tready)
        else $error("input stalled with empty result register");

    a_held_peak_covers: assert property (@(posedge clk) disable iff (!rst_n)
        (commit && !decay_on) |=> (out_pk_reg >= out_sm_reg))
        else $error("held peak below smoothed level");

    a_new_peak_no_decay: assert property (@(posedge clk) disable iff (!rst_n)
        (commit && new_peak) |-> !decay_on)
        else $error("fresh peak decayed in the same item");

endmodule
